// File: hw/rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// No dependencies; imported by pcxrle_step and pcx_rle_scanline_decoder.
package pcxrle_pkg;

    localparam int unsigned CodeW   = 8;
    localparam int unsigned CountW  = 6;
    localparam int unsigned CfgW    = 13;
    localparam int unsigned PlaneW  = 3;
    localparam int unsigned PosW    = 13;
    localparam int unsigned CoordW  = 12;
    localparam int unsigned DataW   = 40;

    localparam logic [CodeW-1:0]  RUN_MARK  = 8'hC0;
    localparam logic [CountW-1:0] RUN_MASK  = 6'h3F;
    localparam logic [CfgW-1:0]   DIM_LIMIT = 13'd4096;

    localparam logic STATUS_PIXEL  = 1'b0;
    localparam logic STATUS_DEPTH  = 1'b1;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LINE_BYTES   = 2'd2,
        REG_PLANE_COUNT  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // Result of one decode step at the current line position.
    typedef struct packed {
        logic              emit;
        logic              run_end;
        logic              image_end;
        logic              last_iter;
        logic [PosW-1:0]   pos_next;
        logic [CoordW-1:0] idx_next;
    } step_res_t;

endpackage

// File: hw/rtl/pcxrle_step.sv
// Shared step unit: one line position per use, emit test and line wrap.
// Depends on pcxrle_pkg.
module pcxrle_step (
    input  logic [pcxrle_pkg::PosW-1:0]   pos,
    input  logic [pcxrle_pkg::CountW-1:0] cnt,
    input  logic [pcxrle_pkg::CoordW-1:0] idx,
    input  logic [pcxrle_pkg::CfgW-1:0]   width_eff,
    input  logic [pcxrle_pkg::CfgW-1:0]   height_eff,
    input  logic [pcxrle_pkg::CfgW-1:0]   len_eff,
    output pcxrle_pkg::step_res_t         res
);
    import pcxrle_pkg::*;

    logic [PosW:0]   pos_inc;
    logic [CoordW:0] idx_inc;
    logic            line_done;
    logic            last_row;

    always_comb begin
        pos_inc   = {1'b0, pos} + {{PosW{1'b0}}, 1'b1};
        idx_inc   = {1'b0, idx} + {{CoordW{1'b0}}, 1'b1};
        line_done = pos_inc >= {1'b0, len_eff};
        last_row  = idx_inc >= height_eff;

        res.emit      = pos < width_eff;
        res.last_iter = line_done || (cnt == {{(CountW-1){1'b0}}, 1'b1});
        // The next position emits only if the run goes on and it is still visible.
        res.run_end   = res.last_iter || (pos_inc >= {1'b0, width_eff});
        res.image_end = (pos_inc == {1'b0, width_eff}) && last_row;
        res.pos_next  = line_done ? '0 : pos_inc[PosW-1:0];
        if (line_done) begin
            res.idx_next = last_row ? '0 : idx_inc[CoordW-1:0];
        end else begin
            res.idx_next = idx;
        end
    end

endmodule

// File: hw/rtl/pcx_rle_scanline_decoder.sv
// PCX run-length scanline decoder: a literal or run data byte enters the run state,
// which steps one line position per cycle, while the output register is free, via
// the shared step unit until the run or the line ends. A run prefix only stores its
// count. An output register lets the next item enter while a result waits.
// Reset (aresetn low at a clock edge) clears the decoder state and sets every
// configuration register to 1.
module pcx_rle_scanline_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    // Coded byte input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    // Decoded results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pixel, [19:8] column, [31:20] row, [32] image_end
    output logic        m_tlast,   // run_end: last result caused by one input item
    output logic        m_tuser    // status: 0 pixel, 1 unsupported depth
);
    import pcxrle_pkg::*;

    // Configuration registers.
    logic [CfgW-1:0]   width_reg, height_reg, lbytes_reg;
    logic [PlaneW-1:0] planes_reg;

    // Decoder state.
    state_t            state_reg, state_next;
    logic              await_reg, await_next;
    logic [CountW-1:0] run_cnt_reg, run_cnt_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic [CodeW-1:0]  byte_reg, byte_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [CoordW-1:0] idx_reg, idx_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [DataW-1:0]  m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic              out_free, in_acc, unsupported, is_prefix, step_go;
    logic [CountW-1:0] in_count;
    logic [CfgW-1:0]   width_eff, height_eff, len_eff, len_raw, lb_eff;
    step_res_t         st;

    // Width and height clamp to 4096 since column and row are 12 bits.
    // The coded line length is at least the visible width and never zero.
    always_comb begin
        width_eff  = (width_reg > DIM_LIMIT) ? DIM_LIMIT : width_reg;
        height_eff = (height_reg > DIM_LIMIT) ? DIM_LIMIT : height_reg;
        if (height_eff == '0) begin
            height_eff = {{(CfgW-1){1'b0}}, 1'b1};
        end
        lb_eff  = (planes_reg == '0) ? '0 : lbytes_reg;
        len_raw = (lb_eff < width_reg) ? width_reg : lb_eff;
        len_eff = (len_raw == '0) ? {{(CfgW-1){1'b0}}, 1'b1} : len_raw;
    end

    pcxrle_step u_step (
        .pos        (pos_reg),
        .cnt        (cnt_reg),
        .idx        (idx_reg),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .len_eff    (len_eff),
        .res        (st)
    );

    // Handshake and input decode. More than one plane is not decoded: each such
    // item yields one status result and leaves the decoder state alone. Only that
    // status item writes the output register on acceptance, so only it waits for
    // the register to be free; a literal or prefix enters while a result waits.
    always_comb begin
        out_free    = !m_valid_reg || m_tready;
        unsupported = planes_reg > {{(PlaneW-1){1'b0}}, 1'b1};
        s_tready    = (state_reg == ST_IDLE) && (out_free || !unsupported);
        in_acc      = s_tvalid && s_tready;
        is_prefix   = !await_reg && ((s_tdata & RUN_MARK) == RUN_MARK);
        in_count    = await_reg ? run_cnt_reg : {{(CountW-1){1'b0}}, 1'b1};
        step_go     = (state_reg == ST_RUN) && out_free;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && !unsupported && !is_prefix && (in_count != '0)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_go && st.last_iter) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        await_next   = await_reg;
        run_cnt_next = run_cnt_reg;
        cnt_next     = cnt_reg;
        byte_next    = byte_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (unsupported) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        m_last_next  = 1'b1;
                        m_user_next  = STATUS_DEPTH;
                    end else if (is_prefix) begin
                        await_next   = 1'b1;
                        run_cnt_next = s_tdata[CountW-1:0] & RUN_MASK;
                    end else begin
                        // A literal, or the data byte of a run (a zero count just ends it).
                        await_next   = 1'b0;
                        run_cnt_next = '0;
                        cnt_next     = in_count;
                        byte_next    = s_tdata;
                    end
                end
            end
            ST_RUN: begin
                if (step_go) begin
                    cnt_next = cnt_reg - {{(CountW-1){1'b0}}, 1'b1};
                    pos_next = st.pos_next;
                    idx_next = st.idx_next;
                    if (st.emit) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {{(DataW-33){1'b0}}, st.image_end, idx_reg,
                                        pos_reg[CoordW-1:0], byte_reg};
                        m_last_next  = st.run_end;
                        m_user_next  = STATUS_PIXEL;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= {{(CfgW-1){1'b0}}, 1'b1};
            height_reg  <= {{(CfgW-1){1'b0}}, 1'b1};
            lbytes_reg  <= {{(CfgW-1){1'b0}}, 1'b1};
            planes_reg  <= {{(PlaneW-1){1'b0}}, 1'b1};
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                REG_LINE_BYTES:   lbytes_reg <= cfg_wdata;
                REG_PLANE_COUNT:  planes_reg <= cfg_wdata[PlaneW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            await_reg   <= 1'b0;
            run_cnt_reg <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            await_reg   <= await_next;
            run_cnt_reg <= run_cnt_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
